// File: hw/rtl/retrieval_pointer_extent_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Retrieval pointer extent parser assertion macros
// Shared concurrent assertion forms for the parser's RTL files.
// ----------------------------------------------------------------------------
`ifndef RETRIEVAL_POINTER_EXTENT_PARSER_UNIT_DEFINES_SVH
`define RETRIEVAL_POINTER_EXTENT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the clock and disabled during reset.
`define RPEP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser assertion failed");

// Next-cycle implication, sampled on the clock and disabled during reset.
`define RPEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser assertion failed");

`endif

// File: hw/rtl/rpep_pkg.sv
// ----------------------------------------------------------------------------
// Retrieval pointer extent parser package
// Types and constants shared by the parser's decode, result and top modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rpep_pkg;

   // Field positions and masks of a pointer's first word.
   localparam int unsigned FMT_SHIFT  = 14;
   localparam int unsigned HALF_SHIFT = 16;
   localparam logic [15:0] F1_CNT_MASK  = 16'o0377;
   localparam logic [15:0] F1_HI_MASK   = 16'o037400;
   localparam logic [15:0] F23_CNT_MASK = 16'o037777;

   // Pointer format codes from the top two bits of the first word.
   localparam logic [1:0] FMT_PLACEMENT = 2'd0;
   localparam logic [1:0] FMT_ONE       = 2'd1;
   localparam logic [1:0] FMT_TWO       = 2'd2;
   localparam logic [1:0] FMT_THREE     = 2'd3;

   // Running virtual block number after a restart.
   localparam logic [31:0] VBN_START = 32'd1;

   // Position of the next word within the current pointer.
   typedef enum logic [1:0] {
      POS_FIRST,
      POS_SECOND,
      POS_THIRD,
      POS_FOURTH
   } pos_type;

   // One map word with its framing flags.
   typedef struct packed {
      logic [15:0] map_word;
      logic        first_of_map;
      logic        last_of_map;
   } word_type;

   // One result word.
   typedef struct packed {
      logic        extent_valid;
      logic [31:0] start_vbn;
      logic [31:0] start_lbn;
      logic [30:0] block_count;
      logic        truncated;
      logic        map_done;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/rpep_decode.sv
// ----------------------------------------------------------------------------
// Retrieval pointer decode
// Holds the parse state and decodes the current map word into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module rpep_decode (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  rpep_pkg::word_type  word,
   output logic                has_result,
   output rpep_pkg::result_type result
);

   rpep_pkg::pos_type pos_ff, pos_in, cur_pos;
   logic [1:0]  format_ff, format_in, cur_format;
   logic [15:0] hold1_ff, hold1_in;
   logic [15:0] hold2_ff, hold2_in;
   logic [15:0] hold3_ff, hold3_in;
   logic [31:0] vbn_ff, vbn_in, cur_vbn;
   logic        complete;
   logic [30:0] count;
   logic [31:0] lbn;
   logic [15:0] w;

   // A first word restarts the parse before it is decoded.
   always_comb begin
      w = word.map_word;
      cur_pos = word.first_of_map ? rpep_pkg::POS_FIRST : pos_ff;
      cur_vbn = word.first_of_map ? rpep_pkg::VBN_START : vbn_ff;
      cur_format = format_ff;
      complete = 1'b0;
      count = '0;
      lbn = '0;
      pos_in = cur_pos;
      hold1_in = hold1_ff;
      hold2_in = hold2_ff;
      hold3_in = hold3_ff;
      case (cur_pos)
         rpep_pkg::POS_FIRST: begin
            cur_format = w[rpep_pkg::FMT_SHIFT +: 2];
            hold1_in = w;
            if (cur_format != rpep_pkg::FMT_PLACEMENT) begin
               pos_in = rpep_pkg::POS_SECOND;
            end
         end
         rpep_pkg::POS_SECOND: begin
            hold2_in = w;
            if (cur_format == rpep_pkg::FMT_ONE) begin
               count = {23'd0, hold1_ff[7:0] & rpep_pkg::F1_CNT_MASK[7:0]} + 31'd1;
               lbn = {10'd0, hold1_ff[13:8] & rpep_pkg::F1_HI_MASK[13:8], w};
               complete = 1'b1;
            end else begin
               pos_in = rpep_pkg::POS_THIRD;
            end
         end
         rpep_pkg::POS_THIRD: begin
            hold3_in = w;
            if (cur_format == rpep_pkg::FMT_TWO) begin
               count = {17'd0, hold1_ff[13:0] & rpep_pkg::F23_CNT_MASK[13:0]} + 31'd1;
               lbn = {w, hold2_ff};
               complete = 1'b1;
            end else begin
               pos_in = rpep_pkg::POS_FOURTH;
            end
         end
         default: begin
            count = {1'b0, hold1_ff[13:0] & rpep_pkg::F23_CNT_MASK[13:0], hold2_ff}
                    + 31'd1;
            lbn = {w, hold3_ff};
            complete = 1'b1;
         end
      endcase
      format_in = cur_format;
      vbn_in = cur_vbn;

      // Build the result word and close the pointer or the map.
      result = '0;
      has_result = 1'b0;
      if (complete) begin
         has_result = 1'b1;
         result.extent_valid = 1'b1;
         result.start_vbn = cur_vbn;
         result.start_lbn = lbn;
         result.block_count = count;
         result.map_done = word.last_of_map;
         vbn_in = cur_vbn + {1'b0, count};
         pos_in = rpep_pkg::POS_FIRST;
      end else if (word.last_of_map) begin
         has_result = 1'b1;
         result.truncated = (pos_in != rpep_pkg::POS_FIRST);
         result.map_done = 1'b1;
         pos_in = rpep_pkg::POS_FIRST;
      end
   end

   // Control state, updated only when a word is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= rpep_pkg::POS_FIRST;
         format_ff <= rpep_pkg::FMT_PLACEMENT;
         vbn_ff <= rpep_pkg::VBN_START;
      end else if (step) begin
         pos_ff <= pos_in;
         format_ff <= format_in;
         vbn_ff <= vbn_in;
      end
   end

   // Held pointer words.
   always_ff @(posedge clock) begin
      if (step) begin
         hold1_ff <= hold1_in;
         hold2_ff <= hold2_in;
         hold3_ff <= hold3_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rpep_result_reg.sv
// ----------------------------------------------------------------------------
// Retrieval pointer result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpep_result_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  rpep_pkg::result_type  result_in,
   input  wire                   rsp_stall,
   output logic                  out_free,
   output logic                  out_valid,
   output rpep_pkg::result_type  result_out
);

   logic                 valid_ff, valid_in;
   rpep_pkg::result_type data_ff;

   // The register frees up in the same cycle its word is taken.
   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      out_valid = valid_ff;
      result_out = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/retrieval_pointer_extent_parser_unit.sv
// ----------------------------------------------------------------------------
// Retrieval pointer extent parser
// Decodes the words of a file header map area into extents.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one 16-bit map word per cycle with its first and
// last flags; a word is taken when req_valid is high and req_stall is low.
// The rsp_ channel gives one result word per completed retrieval pointer,
// and one at the end of the map when the last word closes no pointer; a
// word is taken when rsp_valid is high and rsp_stall is low.
// Path: a map word is held in the input register, and its result is then
// held in the result register, where it is offered on the rsp_ channel.
// Throughput: one map word per cycle while no result waits for the result
// register, set by the single decode pass between the two registers.
// A map word that yields no result passes through even while the receiver
// stalls; a word that yields a result waits in the input register until the
// result register is free, and req_stall then rises.
// Reset empties both registers, returns the parse to a pointer's first
// word and sets the running virtual block number to one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "retrieval_pointer_extent_parser_unit_defines.svh"

module retrieval_pointer_extent_parser_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [15:0] req_map_word,
   input  wire         req_first_of_map,
   input  wire         req_last_of_map,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_extent_valid,
   output logic [31:0] rsp_start_vbn,
   output logic [31:0] rsp_start_lbn,
   output logic [30:0] rsp_block_count,
   output logic        rsp_truncated,
   output logic        rsp_map_done
);

   logic                 in_valid_ff, in_valid_in;
   rpep_pkg::word_type   in_word_ff;
   logic                 req_take;
   logic                 advance;
   logic                 has_result;
   logic                 out_free;
   rpep_pkg::result_type dec_result;
   rpep_pkg::result_type out_result;

   // A held word advances unless its result has nowhere to go.
   always_comb begin
      advance = in_valid_ff && (!has_result || out_free);
      req_stall = in_valid_ff && !advance;
      req_take = req_valid && !req_stall;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.map_word <= req_map_word;
         in_word_ff.first_of_map <= req_first_of_map;
         in_word_ff.last_of_map <= req_last_of_map;
      end
   end

   rpep_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .word       (in_word_ff),
      .has_result (has_result),
      .result     (dec_result)
   );

   rpep_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .result_in  (dec_result),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .out_valid  (rsp_valid),
      .result_out (out_result)
   );

   // Result word onto the ports.
   always_comb begin
      rsp_extent_valid = out_result.extent_valid;
      rsp_start_vbn = out_result.start_vbn;
      rsp_start_lbn = out_result.start_lbn;
      rsp_block_count = out_result.block_count;
      rsp_truncated = out_result.truncated;
      rsp_map_done = out_result.map_done;
   end

   // A result without an extent only ever closes a map.
   `RPEP_ASSERT_NOW(a_empty_closes_map, clock, reset, rsp_valid && !rsp_extent_valid, rsp_map_done && rsp_start_vbn == 32'd0 && rsp_block_count == 31'd0)
   // An extent is never flagged as truncated and always has blocks.
   `RPEP_ASSERT_NOW(a_extent_whole, clock, reset, rsp_valid && rsp_extent_valid, !rsp_truncated && rsp_block_count != 31'd0)
   // A stalled result with a waiting word holds the input side back.
   `RPEP_ASSERT_NOW(a_stall_backs_up, clock, reset, rsp_valid && rsp_stall && in_valid_ff && has_result, req_stall)
   // A word that leaves the input register with a result lands in the result register.
   `RPEP_ASSERT_NEXT(a_result_loaded, clock, reset, advance && has_result, rsp_valid)

endmodule

`default_nettype wire
